// File: hdl/mt_pkg.sv
// ----------------------------------------------------------------------------
// mt_pkg: shared types, constants and function of the MT19937 generator
// Command codes, sequencer states, multiplier selects and the tempering step.
// ----------------------------------------------------------------------------
`default_nettype none

package mt_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int ADDR_W       = $clog2(STATE_WORDS);
  localparam int CNT_W        = $clog2(STATE_WORDS + 1);
  localparam int MID_WRAP     = STATE_WORDS - TWIST_OFFSET;

  localparam logic [31:0] MATRIX_A      = 32'h9908_b0df;
  localparam logic [31:0] UPPER_MASK    = 32'h8000_0000;
  localparam logic [31:0] INIT_MULT     = 32'd1812433253;
  localparam logic [31:0] KEY_BASE_SEED = 32'h012B_D6AA;
  localparam logic [31:0] MIX_MULT_ONE  = 32'h0019_660D;
  localparam logic [31:0] MIX_MULT_TWO  = 32'h5D58_8B65;
  localparam logic [31:0] TEMPER_B      = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C      = 32'hefc6_0000;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  count_t;

  typedef enum logic [1:0] {
    CMD_NEXT      = 2'd0,
    CMD_SEED_WORD = 2'd1,
    CMD_SEED_KEY  = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MUL_INIT,
    MUL_MIX_ONE,
    MUL_MIX_TWO
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIN_ZERO,
    ST_LIN_MUL,
    ST_LIN_WR,
    ST_MIX_RD,
    ST_MIX_WR,
    ST_MIX_CHK,
    ST_FINAL,
    ST_NX_CUR,
    ST_NX_NXT,
    ST_NX_MID,
    ST_NX_TWIST,
    ST_NX_OUT
  } state_t;

  // Write port of the state store
  typedef struct packed {
    logic        we;
    addr_t       waddr;
    logic [31:0] wdata;
  } wr_req_t;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] t;
    t = w ^ (w >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

endpackage

`default_nettype wire

// File: hdl/mt19937_generator.sv
// ----------------------------------------------------------------------------
// mt19937_generator: MT19937 word generator with a 624-word state store
// Sequencer over one state RAM and one shared seeding multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel; s_tuser carries the command (next word,
//   seed from one word, seed from a two-word key) and s_tdata the seed words.
//   Each next request returns one tempered word on the m_ channel; seed
//   requests and a next request before any seed return nothing, and the
//   unused command code is dropped.
//   One request is worked on at a time; s_tready is high only while idle.
//   Next: three single-port reads (current, neighbor, offset word), then
//   twist-and-write, output load, and the return to idle that takes the
//   next request.
//   Seed from one word: word 0 is written, then each further word takes two
//   steps through the shared multiplier (multiply, then add and write).
//   Seed from key: the linear fill, then 624 + 623 mixing steps, each a
//   read, a combine and write and a wrap check, plus one final write.
//   Reset clears the sequencer, the position and the seeded flag; the state
//   RAM is not cleared and is only read after a seed has filled it.
//   When the receiver stalls, the result waits in the output register and the
//   block still takes the next request; only a second result holds in its
//   last state until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module mt19937_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [95:0] s_tdata,  // seed_value[31:0], key_first[63:32], key_second[95:64]
  input  wire logic [1:0]  s_tuser,  // cmd[1:0]
  // result channel
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata   // random_word[31:0]
);

  import mt_pkg::*;

  localparam addr_t  LAST_IDX   = ADDR_W'(STATE_WORDS - 1);
  localparam addr_t  FIRST_IDX  = ADDR_W'(1);
  localparam addr_t  ZERO_IDX   = '0;
  localparam addr_t  OFFSET_IDX = ADDR_W'(TWIST_OFFSET);
  localparam addr_t  WRAP_IDX   = ADDR_W'(MID_WRAP);
  localparam count_t PASS_ONE_N = CNT_W'(STATE_WORDS);
  localparam count_t PASS_TWO_N = CNT_W'(STATE_WORDS - 1);

  state_t      state, state_next;
  cmd_t        cmd;
  logic        accept;

  // sequencer registers
  addr_t       idx;
  count_t      cnt;
  logic [31:0] prev;
  logic [31:0] key_first;
  logic [31:0] key_second;
  logic        key_mode;
  logic        pass_two;
  logic        jbit;
  logic        wrap;
  addr_t       pos;
  logic        seeded;
  logic        y_upper;
  logic [30:0] y_lower;
  logic [31:0] tempered;

  // datapath
  wr_req_t     wr;
  addr_t       raddr;
  logic [31:0] rdata;
  logic [31:0] prod;
  mul_sel_t    mul_sel;
  logic [31:0] lin_word;
  logic [31:0] mix_word;
  logic [31:0] twist_word;
  logic [31:0] y_word;
  addr_t       pos_nxt;
  addr_t       pos_mid;
  logic        out_load;

  assign cmd      = cmd_t'(s_tuser);
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign pos_nxt = (pos == LAST_IDX) ? ZERO_IDX : pos + FIRST_IDX;
  assign pos_mid = (pos >= WRAP_IDX) ? pos - WRAP_IDX : pos + OFFSET_IDX;

  assign lin_word = prod + 32'(idx);
  // key pass adds key word and j; the second pass subtracts the index
  assign mix_word = pass_two ? ((rdata ^ prod) - 32'(idx))
                             : ((rdata ^ prod) + (jbit ? key_second : key_first)
                                + 32'(jbit));
  assign y_word     = {y_upper, y_lower};
  assign twist_word = rdata ^ (y_word >> 1) ^ (y_word[0] ? MATRIX_A : 32'h0);

  assign out_load = (state == ST_NX_OUT) && (!m_tvalid || m_tready);

  mt_ram #(
    .DEPTH(STATE_WORDS),
    .WIDTH(32)
  ) u_ram (
    .clk  (clk),
    .we   (wr.we),
    .waddr(wr.waddr),
    .wdata(wr.wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  mt_mul u_mul (
    .clk (clk),
    .word(prev),
    .sel (mul_sel),
    .prod(prod)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd == CMD_SEED_WORD || cmd == CMD_SEED_KEY) begin
            state_next = ST_LIN_ZERO;
          end else if (cmd == CMD_NEXT && seeded) begin
            state_next = ST_NX_CUR;
          end
        end
      end
      ST_LIN_ZERO: state_next = ST_LIN_MUL;
      ST_LIN_MUL:  state_next = ST_LIN_WR;
      ST_LIN_WR: begin
        if (idx == LAST_IDX) begin
          state_next = key_mode ? ST_MIX_RD : ST_IDLE;
        end else begin
          state_next = ST_LIN_MUL;
        end
      end
      ST_MIX_RD: state_next = ST_MIX_WR;
      ST_MIX_WR: state_next = ST_MIX_CHK;
      ST_MIX_CHK: begin
        if (pass_two && cnt == PASS_TWO_N) begin
          state_next = ST_FINAL;
        end else begin
          state_next = ST_MIX_RD;
        end
      end
      ST_FINAL:    state_next = ST_IDLE;
      ST_NX_CUR:   state_next = ST_NX_NXT;
      ST_NX_NXT:   state_next = ST_NX_MID;
      ST_NX_MID:   state_next = ST_NX_TWIST;
      ST_NX_TWIST: state_next = ST_NX_OUT;
      ST_NX_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // RAM and multiplier controls
  always_comb begin
    wr      = '{we: 1'b0, waddr: idx, wdata: prev};
    raddr   = idx;
    mul_sel = MUL_INIT;
    unique case (state)
      ST_LIN_ZERO: wr = '{we: 1'b1, waddr: ZERO_IDX, wdata: prev};
      ST_LIN_WR:   wr = '{we: 1'b1, waddr: idx, wdata: lin_word};
      ST_MIX_RD: begin
        raddr   = idx;
        mul_sel = pass_two ? MUL_MIX_TWO : MUL_MIX_ONE;
      end
      ST_MIX_WR:   wr = '{we: 1'b1, waddr: idx, wdata: mix_word};
      // copy the last word to word 0 when the index wrapped
      ST_MIX_CHK:  wr = '{we: wrap, waddr: ZERO_IDX, wdata: prev};
      ST_FINAL:    wr = '{we: 1'b1, waddr: ZERO_IDX, wdata: UPPER_MASK};
      ST_NX_CUR:   raddr = pos;
      ST_NX_NXT:   raddr = pos_nxt;
      ST_NX_MID:   raddr = pos_mid;
      ST_NX_TWIST: wr = '{we: 1'b1, waddr: pos, wdata: twist_word};
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pos    <= '0;
      seeded <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_LIN_WR: begin
          if (idx == LAST_IDX && !key_mode) begin
            pos    <= '0;
            seeded <= 1'b1;
          end
        end
        ST_FINAL: begin
          pos    <= '0;
          seeded <= 1'b1;
        end
        ST_NX_TWIST: pos <= pos_nxt;
        default: begin
        end
      endcase
    end
  end

  // sequencer payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          prev       <= (cmd == CMD_SEED_KEY) ? KEY_BASE_SEED : s_tdata[31:0];
          key_first  <= s_tdata[63:32];
          key_second <= s_tdata[95:64];
          key_mode   <= (cmd == CMD_SEED_KEY);
        end
      end
      ST_LIN_ZERO: idx <= FIRST_IDX;
      ST_LIN_WR: begin
        if (idx == LAST_IDX) begin
          // mixing starts from word 0, which still holds the base seed
          prev     <= KEY_BASE_SEED;
          idx      <= FIRST_IDX;
          cnt      <= '0;
          jbit     <= 1'b0;
          pass_two <= 1'b0;
        end else begin
          prev <= lin_word;
          idx  <= idx + FIRST_IDX;
        end
      end
      ST_MIX_WR: begin
        prev <= mix_word;
        cnt  <= cnt + CNT_W'(1);
        jbit <= ~jbit;
        wrap <= (idx == LAST_IDX);
        idx  <= (idx == LAST_IDX) ? FIRST_IDX : idx + FIRST_IDX;
      end
      ST_MIX_CHK: begin
        if (!pass_two && cnt == PASS_ONE_N) begin
          pass_two <= 1'b1;
          cnt      <= '0;
        end
      end
      ST_NX_NXT:   y_upper  <= rdata[31];
      ST_NX_MID:   y_lower  <= rdata[30:0];
      ST_NX_TWIST: tempered <= temper(twist_word);
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= tempered;
    end
  end

endmodule

`default_nettype wire

// File: hdl/mt_ram.sv
// ----------------------------------------------------------------------------
// mt_ram: single-write, single-read synchronous RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module mt_ram #(
  parameter int DEPTH = 624,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/mt_mul.sv
// ----------------------------------------------------------------------------
// mt_mul: shared seeding multiplier
// Registered low word of (w ^ (w >> 30)) times the selected seeding constant.
// ----------------------------------------------------------------------------
`default_nettype none

module mt_mul (
  input  wire logic             clk,
  input  wire logic [31:0]      word,
  input  wire mt_pkg::mul_sel_t sel,
  output logic      [31:0]      prod
);

  import mt_pkg::*;

  logic [31:0] operand;
  logic [31:0] factor;

  assign operand = word ^ (word >> 30);

  always_comb begin
    unique case (sel)
      MUL_INIT:    factor = INIT_MULT;
      MUL_MIX_ONE: factor = MIX_MULT_ONE;
      MUL_MIX_TWO: factor = MIX_MULT_TWO;
      default:     factor = INIT_MULT;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= operand * factor;
  end

endmodule

`default_nettype wire

// File: hdl/mt_checker.sv
// ----------------------------------------------------------------------------
// mt_checker: port-level checks of the MT19937 generator
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  import mt_pkg::*;

  // a result held back by the receiver keeps its word
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a word seed keeps the request side closed once it is taken
  a_seed_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == CMD_SEED_WORD |=> !s_tready ##1 !s_tready)
    else $error("request taken during seeding");

  // a result never appears the cycle after a request is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result appeared too early");

endmodule

bind mt19937_generator mt_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

`default_nettype wire

// File: test/mt_word_checker.sv
// ----------------------------------------------------------------------------
// mt_word_checker: prediction and comparison for the MT19937 generator
// Watches the request and result channels, keeps its own copy of the twister
// state, and compares every returned word with the oldest predicted word.
// ----------------------------------------------------------------------------

module mt_word_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [95:0] s_tdata,   // seed_value[31:0], key_first[63:32], key_second[95:64]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // random_word[31:0]
  output int          word_errors,
  output int          words_due
);

  localparam int NWORDS     = 624;
  localparam int SHIFT_SPAN = 397;

  localparam logic [31:0] TWIST_XOR  = 32'h9908_b0df;
  localparam logic [31:0] HIGH_BIT   = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS   = 32'h7fff_ffff;
  localparam logic [31:0] LIN_MULT   = 32'd1812433253;
  localparam logic [31:0] KEY_START  = 32'd19650218;
  localparam logic [31:0] MIX_A_MULT = 32'h0019_660D;
  localparam logic [31:0] MIX_B_MULT = 32'h5D58_8B65;
  localparam logic [31:0] TEMPER_M1  = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_M2  = 32'hefc6_0000;

  logic [31:0] mt_words [NWORDS];
  int          mt_pos;
  logic        mt_seeded;
  logic [31:0] predicted_words [$];
  logic [31:0] oldest_word;
  logic [31:0] fresh_word;

  function automatic void fill_linear(input logic [31:0] start);
    logic [31:0] prev;
    logic [31:0] idx;
    mt_words[0] = start;
    for (int k = 1; k < NWORDS; k++) begin
      prev = mt_words[k-1];
      idx  = 32'(k);
      mt_words[k] = LIN_MULT * (prev ^ (prev >> 30)) + idx;
    end
    mt_pos    = 0;
    mt_seeded = 1'b1;
  endfunction

  function automatic void fill_from_key(input logic [31:0] first, input logic [31:0] second);
    logic [31:0] key_words [2];
    logic [31:0] prev;
    logic [31:0] i_word;
    logic [31:0] j_word;
    int          i;
    int          j;
    key_words[0] = first;
    key_words[1] = second;
    fill_linear(KEY_START);
    i = 1;
    j = 0;
    // first mixing pass folds the key in
    repeat (NWORDS) begin
      prev   = mt_words[i-1];
      j_word = 32'(j);
      mt_words[i] = (mt_words[i] ^ ((prev ^ (prev >> 30)) * MIX_A_MULT)) + key_words[j] + j_word;
      i++;
      j++;
      if (i >= NWORDS) begin
        mt_words[0] = mt_words[NWORDS-1];
        i = 1;
      end
      if (j >= 2) j = 0;
    end
    // second pass subtracts the running index
    repeat (NWORDS - 1) begin
      prev   = mt_words[i-1];
      i_word = 32'(i);
      mt_words[i] = (mt_words[i] ^ ((prev ^ (prev >> 30)) * MIX_B_MULT)) - i_word;
      i++;
      if (i >= NWORDS) begin
        mt_words[0] = mt_words[NWORDS-1];
        i = 1;
      end
    end
    mt_words[0] = HIGH_BIT;
    mt_pos      = 0;
    mt_seeded   = 1'b1;
  endfunction

  function automatic logic [31:0] twist_and_temper();
    int          cur;
    int          nxt;
    int          mid;
    logic [31:0] y;
    logic [31:0] w;
    cur = mt_pos;
    nxt = (cur + 1 >= NWORDS) ? 0 : cur + 1;
    mid = (cur + SHIFT_SPAN >= NWORDS) ? cur + SHIFT_SPAN - NWORDS : cur + SHIFT_SPAN;
    y = (mt_words[cur] & HIGH_BIT) | (mt_words[nxt] & LOW_BITS);
    w = mt_words[mid] ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'h0);
    mt_words[cur] = w;
    w = w ^ (w >> 11);
    w = w ^ ((w << 7) & TEMPER_M1);
    w = w ^ ((w << 15) & TEMPER_M2);
    w = w ^ (w >> 18);
    mt_pos = nxt;
    return w;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mt_pos    = 0;
      mt_seeded = 1'b0;
      predicted_words.delete();
    end else begin
      // take the returned word first: a request accepted at this edge
      // cannot have produced it
      if (m_tvalid && m_tready) begin
        if (predicted_words.size() == 0) begin
          if (word_errors < 10)
            $display("unexpected random_word %08h at %0t", m_tdata, $realtime);
          word_errors++;
        end else begin
          oldest_word = predicted_words.pop_front();
          if (oldest_word !== m_tdata) begin
            if (word_errors < 10)
              $display("random_word mismatch at %0t: expected %08h, got %08h",
                       $realtime, oldest_word, m_tdata);
            word_errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          mt_pkg::CMD_NEXT: begin
            if (mt_seeded) begin
              fresh_word      = twist_and_temper();
              predicted_words = {predicted_words, fresh_word};
            end
          end
          mt_pkg::CMD_SEED_WORD: fill_linear(s_tdata[31:0]);
          mt_pkg::CMD_SEED_KEY:  fill_from_key(s_tdata[63:32], s_tdata[95:64]);
          default: ;
        endcase
      end
    end
    words_due = predicted_words.size();
  end

endmodule

// File: test/tb_mt19937_generator.sv
// ----------------------------------------------------------------------------
// tb_mt19937_generator: request stimulus and verdict for the MT19937 generator
// Drives seed and next requests with random gaps and result stalls; the
// checker beside the block predicts every word and counts the errors.
// ----------------------------------------------------------------------------

module tb_mt19937_generator;

  localparam int RANDOM_ITEMS = 1250;
  localparam int MAX_GAP      = 17;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;   // seed_value[31:0], key_first[63:32], key_second[95:64]
  logic [1:0]  s_tuser = mt_pkg::CMD_NEXT;   // cmd[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;   // random_word[31:0]

  int word_errors;
  int words_due;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  mt19937_generator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  mt_word_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .word_errors (word_errors),
    .words_due   (words_due)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Present one request after a random gap and hold it until accepted.
  // Called and returning at a falling edge.
  task automatic send_request(input mt_pkg::cmd_t op, input logic [31:0] word_seed,
                              input logic [31:0] key_lo, input logic [31:0] key_hi);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {key_hi, key_lo, word_seed};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Issue a run of next requests; payload bits are don't-care, so randomize them.
  task automatic request_words(input int count);
    repeat (count) send_request(mt_pkg::CMD_NEXT, $urandom, $urandom, $urandom);
  endtask

  // Result side: stall for a random number of cycles per word, with bursts
  // of back-to-back acceptance now and then.
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
      @(negedge clk);
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("mt19937_generator verification failed");
    $finish;
  end

  initial begin
    int          sent;
    int          run_len;
    int          drain;
    bit          first_run;
    logic [31:0] seed_a;
    logic [31:0] seed_b;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: requests before any seed must stay silent, then the
    // seed extremes, both seeding modes, a seed right after a seed, and
    // the unused code both before and inside a run.
    request_words(1);
    send_request(mt_pkg::CMD_UNUSED, $urandom, $urandom, $urandom);
    request_words(1);
    send_request(mt_pkg::CMD_SEED_WORD, 32'h0000_0000, $urandom, $urandom);
    request_words(3);
    send_request(mt_pkg::CMD_SEED_WORD, 32'hffff_ffff, $urandom, $urandom);
    request_words(2);
    send_request(mt_pkg::CMD_SEED_KEY, $urandom, 32'h0000_0000, 32'h0000_0000);
    request_words(2);
    send_request(mt_pkg::CMD_SEED_KEY, $urandom, 32'hffff_ffff, 32'hffff_ffff);
    request_words(1);
    send_request(mt_pkg::CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    request_words(1);
    send_request(mt_pkg::CMD_SEED_WORD, 32'd5489, $urandom, $urandom);
    send_request(mt_pkg::CMD_SEED_KEY, $urandom, 32'h0000_0123, 32'h0000_0234);
    request_words(2);
    send_request(mt_pkg::CMD_SEED_KEY, $urandom, 32'haaaa_aaaa, 32'h5555_5555);
    request_words(2);

    // Random part: sessions of one seed followed by a run of next requests.
    // The first run goes well past one full pass over the store so that
    // words twisted earlier feed later twists.
    sent      = 0;
    first_run = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      seed_a   = $urandom;
      seed_b   = $urandom;
      if ($urandom_range(0, 7) == 0) seed_a = '0;
      if ($urandom_range(0, 7) == 0) seed_b = '1;
      if ($urandom_range(0, 1) == 0)
        send_request(mt_pkg::CMD_SEED_WORD, seed_a, $urandom, $urandom);
      else
        send_request(mt_pkg::CMD_SEED_KEY, $urandom, seed_a, seed_b);
      sent++;

      if (first_run) run_len = 700;
      else if ($urandom_range(0, 7) == 0) run_len = 0;
      else run_len = $urandom_range(30, 90);
      first_run = 1'b0;

      for (int n = 0; n < run_len; n++) begin
        // drop in an ignored code now and then
        if ($urandom_range(0, 19) == 0)
          send_request(mt_pkg::CMD_UNUSED, $urandom, $urandom, $urandom);
        request_words(1);
        sent++;
      end
    end
    s_tvalid <= 1'b0;

    // Drain: wait for every predicted word and for the block to go idle
    drain = 0;
    while ((words_due != 0 || !s_tready) && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (50) @(posedge clk);

    if (word_errors == 0 && words_due == 0) begin
      $display("mt19937_generator verification clean");
    end else begin
      $display("mt19937_generator verification failed");
    end
    $finish;
  end

endmodule
